/* design/int_to_radix_ascii_assert.svh */
// assertion macros for the int_to_radix_ascii block
// expects signals clk and arst_n in the scope where a macro is used
`ifndef INT_TO_RADIX_ASCII_ASSERT_SVH
`define INT_TO_RADIX_ASCII_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ITRA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define ITRA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/itra_pkg.sv */
// shared types and constants for the int_to_radix_ascii block
// no dependencies
package itra_pkg;

	// widths and depths
	localparam int VALUE_WIDTH = 32;
	localparam int DIGIT_DEPTH = 32;
	localparam int RADIX_W     = 6;
	localparam int LEN_W       = 6;
	localparam int CHAR_W      = 8;
	localparam int TOT_W       = LEN_W + 1;
	localparam int BIT_W       = $clog2(VALUE_WIDTH);
	localparam int CNT_W       = $clog2(DIGIT_DEPTH + 1);

	// radix limits
	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

	// character codes
	localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
	localparam logic [RADIX_W-1:0] DEC_DIGITS = RADIX_W'(10);

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_DIVIDE = 3'b010,
		ST_EMIT   = 3'b100
	} state_t;

	// digit value to ascii, upper-case letters above nine
	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] ch;
		if (d < DEC_DIGITS) begin
			ch = CHAR_ZERO + CHAR_W'(d);
		end else begin
			ch = CHAR_A + CHAR_W'(d - DEC_DIGITS);
		end
		return ch;
	endfunction

endpackage

/* design/int_to_radix_ascii.sv */
// int_to_radix_ascii: signed integer to zero-padded ascii text in radix 2..36
// depends on itra_pkg and int_to_radix_ascii_assert.svh

// One input transfer is converted at a time. A shared restoring subtract-and-compare
// unit divides the magnitude by the radix one quotient bit per clock. The characters
// then leave at one per cycle while out_stall is low: optional '-', '0' padding up
// to min_length, then the digits most significant first, with last set on the final
// one (at most 63 characters). A radix outside 2..36 gives a single result with
// character 0, last and bad_radix set. in_stall stays high from the input transfer
// until the final character has been loaded into the output register; a new value
// is taken while that character still waits at the output.
module int_to_radix_ascii
	import itra_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic        [RADIX_W-1:0]     radix,
	input  logic        [LEN_W-1:0]       min_length,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic        [CHAR_W-1:0]      character,
	output logic                          last,
	output logic                          bad_radix
);

`include "int_to_radix_ascii_assert.svh"

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic [RADIX_W-1:0]     rem_q;
	logic [RADIX_W-1:0]     radix_q;
	logic [LEN_W-1:0]       min_len_q;
	logic [LEN_W-1:0]       pad_q;
	logic [BIT_W-1:0]       bit_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   neg_q;
	logic                   sign_q;
	logic                   bad_q;
	logic [RADIX_W-1:0]     digit_stack_q [DIGIT_DEPTH];

	logic                   out_valid_q;
	logic [CHAR_W-1:0]      character_q;
	logic                   last_q;
	logic                   bad_radix_q;

	logic                   in_xfer;
	logic                   in_bad;
	logic [VALUE_WIDTH-1:0] val_u;
	logic [VALUE_WIDTH-1:0] mag_in;
	logic [RADIX_W:0]       trial;
	logic                   ge;
	logic [RADIX_W:0]       trial_sub;
	logic [RADIX_W-1:0]     rem_new;
	logic [VALUE_WIDTH-1:0] mag_new;
	logic                   digit_end;
	logic [CNT_W-1:0]       cnt_inc;
	logic                   div_done;
	logic [TOT_W-1:0]       nat_len;
	logic [TOT_W-1:0]       min_ext;
	logic [LEN_W-1:0]       pad_calc;
	logic                   load;
	logic                   push;
	logic                   pop;
	logic [CHAR_W-1:0]      next_char;
	logic                   next_last;
	logic                   next_bad;

	// input handshake and magnitude
	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign in_bad   = (radix < RADIX_MIN) || (radix > RADIX_MAX);
	assign val_u    = value;
	assign mag_in   = val_u[VALUE_WIDTH-1] ? (~val_u + 1'b1) : val_u;

	// shared restoring divide step, one quotient bit per cycle
	assign trial     = {rem_q, mag_q[VALUE_WIDTH-1]};
	assign ge        = (trial >= {1'b0, radix_q});
	assign trial_sub = trial - {1'b0, radix_q};
	assign rem_new   = ge ? trial_sub[RADIX_W-1:0] : trial[RADIX_W-1:0];
	assign mag_new   = {mag_q[VALUE_WIDTH-2:0], ge};
	assign digit_end = (bit_q == BIT_W'(VALUE_WIDTH - 1));
	assign cnt_inc   = cnt_q + 1'b1;
	assign div_done  = (mag_new == '0) || (cnt_inc == CNT_W'(DIGIT_DEPTH));
	assign push      = (state_q == ST_DIVIDE) && digit_end;

	// padding once the digit count is known
	assign nat_len  = TOT_W'(neg_q) + TOT_W'(cnt_inc);
	assign min_ext  = TOT_W'(min_len_q);
	assign pad_calc = (min_ext > nat_len) ? LEN_W'(min_ext - nat_len) : '0;

	// next character in emit order: error, sign, padding, digits
	assign load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	always_comb begin
		next_bad = 1'b0;
		pop      = 1'b0;
		priority if (bad_q) begin
			next_char = CHAR_NONE;
			next_last = 1'b1;
			next_bad  = 1'b1;
		end else if (sign_q) begin
			next_char = CHAR_MINUS;
			next_last = (pad_q == '0) && (cnt_q == '0);
		end else if (pad_q != '0) begin
			next_char = CHAR_ZERO;
			next_last = (pad_q == LEN_W'(1)) && (cnt_q == '0);
		end else begin
			next_char = digit_char(digit_stack_q[0]);
			next_last = (cnt_q == CNT_W'(1));
			pop       = load;
		end
	end

	// sequencer and datapath control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mag_q   <= '0;
			cnt_q   <= '0;
			bit_q   <= '0;
			rem_q   <= '0;
			pad_q   <= '0;
			neg_q   <= 1'b0;
			sign_q  <= 1'b0;
			bad_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && in_bad) begin
						bad_q   <= 1'b1;
						state_q <= ST_EMIT;
					end else if (in_xfer) begin
						bad_q   <= 1'b0;
						mag_q   <= mag_in;
						neg_q   <= val_u[VALUE_WIDTH-1];
						sign_q  <= val_u[VALUE_WIDTH-1];
						cnt_q   <= '0;
						bit_q   <= '0;
						rem_q   <= '0;
						state_q <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					mag_q <= mag_new;
					if (digit_end) begin
						rem_q <= '0;
						bit_q <= '0;
						cnt_q <= cnt_inc;
						if (div_done) begin
							pad_q   <= pad_calc;
							state_q <= ST_EMIT;
						end
					end else begin
						rem_q <= rem_new;
						bit_q <= bit_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (load) begin
						if (bad_q) begin
							bad_q <= 1'b0;
						end else if (sign_q) begin
							sign_q <= 1'b0;
						end else if (pad_q != '0) begin
							pad_q <= pad_q - 1'b1;
						end else begin
							cnt_q <= cnt_q - 1'b1;
						end
						if (next_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// operand registers captured on the input transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			radix_q   <= radix;
			min_len_q <= min_length;
		end
	end

	// digit stack: push at the top while dividing, pop from the top while emitting
	always_ff @(posedge clk) begin
		if (push) begin
			digit_stack_q[0] <= rem_new;
			for (int i = 1; i < DIGIT_DEPTH; i++) begin
				digit_stack_q[i] <= digit_stack_q[i-1];
			end
		end else if (pop) begin
			for (int i = 0; i < DIGIT_DEPTH - 1; i++) begin
				digit_stack_q[i] <= digit_stack_q[i+1];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			character_q <= next_char;
			last_q      <= next_last;
			bad_radix_q <= next_bad;
		end
	end

	assign out_valid = out_valid_q;
	assign character = character_q;
	assign last      = last_q;
	assign bad_radix = bad_radix_q;

	// checks
	`ITRA_ASSERT_NEXT(a_busy_after_xfer, in_xfer, (state_q != ST_IDLE), "not busy after transfer")
	`ITRA_ASSERT_NOW(a_rem_below_radix, (state_q == ST_DIVIDE), (rem_q < radix_q), "remainder not below radix")
	`ITRA_ASSERT_NOW(a_pop_nonempty, pop, (cnt_q != '0), "digit pop from empty stack")
	`ITRA_ASSERT_NOW(a_bad_is_last, (out_valid_q && bad_radix_q), last_q, "error result without last")
	`ITRA_ASSERT_NOW(a_cnt_in_range, 1'b1, (cnt_q <= CNT_W'(DIGIT_DEPTH)), "digit count past depth")

endmodule

/* tb/sv/int_to_radix_ascii_tb.sv */
// self-checking testbench for int_to_radix_ascii: signed value to padded radix text
// a scoreboard class predicts the character stream of every accepted conversion
// depends on itra_pkg and the int_to_radix_ascii rtl

import itra_pkg::*;

// one expected output character
typedef struct packed {
	logic [CHAR_W-1:0] ch;
	logic              fin;
	logic              bad;
} text_char_t;

// predicts the characters of each conversion and checks the output stream against them
class radix_text_scoreboard;
	logic [RADIX_W-1:0]     digit_store [DIGIT_DEPTH];
	int unsigned            digit_count;
	logic [VALUE_WIDTH-1:0] remaining_magnitude;
	text_char_t             expected_chars [$];
	int unsigned            mismatches;
	int unsigned            conversions;
	int unsigned            bad_radix_items;
	int unsigned            chars_checked;

	function new();
		foreach (digit_store[i]) digit_store[i] = '0;
		digit_count = 0;
		remaining_magnitude = '0;
		mismatches = 0;
		conversions = 0;
		bad_radix_items = 0;
		chars_checked = 0;
	endfunction

	function logic [CHAR_W-1:0] digit_to_ascii(logic [RADIX_W-1:0] d);
		if (d < DEC_DIGITS) return CHAR_ZERO + CHAR_W'(d);
		return CHAR_A + CHAR_W'(d - DEC_DIGITS);
	endfunction

	function void add_char(logic [CHAR_W-1:0] ch, logic fin, logic bad);
		text_char_t tc;
		tc.ch = ch;
		tc.fin = fin;
		tc.bad = bad;
		expected_chars.push_back(tc);
	endfunction

	// work out the full character sequence for one input transfer
	function void note_input(logic [VALUE_WIDTH-1:0] v, logic [RADIX_W-1:0] r,
			logic [LEN_W-1:0] ml);
		logic                   negative;
		logic [VALUE_WIDTH-1:0] mag;
		int unsigned            ndig;
		int unsigned            total;
		int unsigned            pad;
		int unsigned            k;
		conversions++;
		// out-of-range base: one error character, state untouched
		if (r < RADIX_MIN || r > RADIX_MAX) begin
			add_char(CHAR_NONE, 1'b1, 1'b1);
			bad_radix_items++;
			return;
		end
		negative = v[VALUE_WIDTH-1];
		mag = negative ? (~v + 1'b1) : v;
		// digits, least significant first
		ndig = 0;
		do begin
			digit_store[ndig] = RADIX_W'(mag % r);
			ndig++;
			mag = mag / r;
		end while (mag != 0 && ndig < DIGIT_DEPTH);
		digit_count = ndig;
		remaining_magnitude = mag;
		total = ndig + negative;
		if (ml > total) total = ml;
		pad = total - negative - ndig;
		// sign, then zero padding, then digits most significant first
		k = 0;
		if (negative) begin
			k++;
			add_char(CHAR_MINUS, k == total, 1'b0);
		end
		repeat (pad) begin
			k++;
			add_char(CHAR_ZERO, k == total, 1'b0);
		end
		for (int i = ndig; i > 0; i--) begin
			k++;
			add_char(digit_to_ascii(digit_store[i-1]), k == total, 1'b0);
		end
	endfunction

	// compare one output transfer with the oldest expected character
	function void check_char(logic [CHAR_W-1:0] ch, logic fin, logic bad);
		text_char_t exp_c;
		if (expected_chars.size() == 0) begin
			$display("%0t: unexpected character: got char=%h last=%b bad_radix=%b",
				$time, ch, fin, bad);
			mismatches++;
			return;
		end
		exp_c = expected_chars.pop_front();
		chars_checked++;
		if (ch !== exp_c.ch) begin
			$display("%0t: character mismatch: expected %h, got %h", $time, exp_c.ch, ch);
			mismatches++;
		end
		if (fin !== exp_c.fin) begin
			$display("%0t: last mismatch: expected %b, got %b", $time, exp_c.fin, fin);
			mismatches++;
		end
		if (bad !== exp_c.bad) begin
			$display("%0t: bad_radix mismatch: expected %b, got %b", $time, exp_c.bad, bad);
			mismatches++;
		end
	endfunction
endclass

module int_to_radix_ascii_tb;
	localparam int HALF_PERIOD    = 4;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASE_ITEMS    = 60;
	localparam int SETTLE_CYCLES  = 100;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic signed [VALUE_WIDTH-1:0] value = '0;
	logic        [RADIX_W-1:0]     radix = '0;
	logic        [LEN_W-1:0]       min_length = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic        [CHAR_W-1:0]      character;
	logic                          last;
	logic                          bad_radix;

	int                   send_idle_pct = 0;
	int                   stall_pct = 0;
	int                   quiet_cycles = 0;
	radix_text_scoreboard sb;

	int_to_radix_ascii uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.radix      (radix),
		.min_length (min_length),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.character  (character),
		.last       (last),
		.bad_radix  (bad_radix)
	);

	// clock
	always #HALF_PERIOD clk = ~clk;

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// check every output transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_char(character, last, bad_radix);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("int_to_radix_ascii_tb: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// present one conversion request, with optional idle cycles ahead of it
	task automatic send_item(input logic [VALUE_WIDTH-1:0] v, input logic [RADIX_W-1:0] r,
			input logic [LEN_W-1:0] ml);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		radix <= r;
		min_length <= ml;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(v, r, ml);
	endtask

	// value mix: full range, small magnitudes of both signs, extremes, short bit patterns
	function automatic logic [VALUE_WIDTH-1:0] pick_value();
		logic [VALUE_WIDTH-1:0] v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = $urandom;
			4, 5:       v = $urandom_range(999);
			6, 7:       v = -$urandom_range(999);
			8: begin
				case ($urandom_range(3))
					0:       v = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
					1:       v = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
					2:       v = '0;
					default: v = '1;
				endcase
			end
			default:    v = $urandom >> $urandom_range(31);
		endcase
		return v;
	endfunction

	function automatic logic [RADIX_W-1:0] pick_radix();
		if ($urandom_range(99) < 85) return RADIX_W'($urandom_range(36, 2));
		return RADIX_W'($urandom_range(63));
	endfunction

	function automatic logic [LEN_W-1:0] pick_min_length();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return LEN_W'($urandom_range(12));
			5, 6:          return LEN_W'($urandom_range(63));
			default:       return '0;
		endcase
	endfunction

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, padding after the sign, no padding, bad bases
		send_item(32'sd0, 6'd10, 6'd0);
		send_item(32'sd0, 6'd2, 6'd63);
		send_item(32'h8000_0000, 6'd2, 6'd0);
		send_item(32'h7fff_ffff, 6'd2, 6'd0);
		send_item(-32'sd1, 6'd36, 6'd0);
		send_item(32'h8000_0000, 6'd36, 6'd63);
		send_item(32'h7fff_ffff, 6'd16, 6'd5);
		send_item(-32'sd255, 6'd16, 6'd8);
		send_item(32'sd35, 6'd36, 6'd1);
		send_item(32'sd12345, 6'd10, 6'd3);
		send_item(-32'sd7, 6'd10, 6'd2);
		send_item(32'sd100, 6'd0, 6'd5);
		send_item(32'sd100, 6'd1, 6'd0);
		send_item(32'sd100, 6'd37, 6'd0);
		send_item(-32'sd5, 6'd63, 6'd63);
		send_item(32'sd123456789, 6'd7, 6'd20);
		send_item(-32'sd42, 6'd3, 6'd0);
		send_item(32'sd1, 6'd2, 6'd1);
		send_item(32'h8000_0000, 6'd10, 6'd12);

		// random conversions under four idle/stall mixes
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0:       begin send_idle_pct = 0;  stall_pct = 0;  end
				1:       begin send_idle_pct = 74; stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  stall_pct = 74; end
				default: begin send_idle_pct = 7;  stall_pct = 7;  end
			endcase
			repeat (PHASE_ITEMS) send_item(pick_value(), pick_radix(), pick_min_length());
		end
		in_valid <= 1'b0;

		// drain outstanding characters, then watch for strays
		stall_pct = 0;
		while (sb.expected_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d conversions (%0d with an out-of-range base), %0d characters",
			sb.conversions, sb.bad_radix_items, sb.chars_checked);
		$display("with no idling, sender gaps, receiver stalls and a light mix of both");
		if (sb.mismatches == 0 && sb.expected_chars.size() == 0) begin
			$display("int_to_radix_ascii_tb: PASS");
		end else begin
			$display("int_to_radix_ascii_tb: FAIL");
		end
		$finish;
	end
endmodule
